// ----- hdl/asbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Arena stack allocator package
// Widths, operation and status codes, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package asbfa_pkg;

    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 41;
    localparam int ALIGN_W   = 13;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Wide enough for base plus offset plus alignment slack and a request.
    localparam int SUM_W = ADDR_W + 2;

    localparam int FREE_SLOTS_DEFAULT = 256;

    // Page size of the committed region; must be a power of two.
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic [SIZE_W-1:0] REGION_RESET = SIZE_W'(64'd1073741824);

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_POP     = 3'd2;
    localparam logic [OP_W-1:0] OP_SAVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd4;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_REGION    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'b1;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic scan_start;
        logic scan_step;
        logic bump_top;
        logic bump_align;
        logic bump_offset;
        logic bump_size;
        logic bump_compare;
        logic bump_page;
        logic finish_simple;
        logic finish_hit;
        logic finish_free;
        logic finish_bump;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic found;
        logic op_alloc;
        logic op_free;
        logic out_busy;
    } stat_t;

endpackage

// ----- hdl/asbfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Arena stack allocator controller
// Sequences the clearing pass, the free-list scan, the bump steps and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module asbfa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  asbfa_pkg::stat_t stat,
    output asbfa_pkg::cmd_t  cmd
);

    typedef enum logic [12:0] {
        ST_CLEAR     = 13'b0000000000001,
        ST_IDLE      = 13'b0000000000010,
        ST_EXEC      = 13'b0000000000100,
        ST_SCAN      = 13'b0000000001000,
        ST_HIT       = 13'b0000000010000,
        ST_FREE      = 13'b0000000100000,
        ST_BUMP_A    = 13'b0000001000000,
        ST_BUMP_B    = 13'b0000010000000,
        ST_BUMP_C    = 13'b0000100000000,
        ST_BUMP_D    = 13'b0001000000000,
        ST_BUMP_E    = 13'b0010000000000,
        ST_BUMP_F    = 13'b0100000000000,
        ST_BUMP_END  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.op_alloc || stat.op_free) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (!stat.out_busy) begin
                    cmd.finish_simple = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    priority if (stat.op_free) begin
                        state_next = ST_FREE;
                    end else if (stat.found) begin
                        state_next = ST_HIT;
                    end else begin
                        state_next = ST_BUMP_A;
                    end
                end
            end
            ST_HIT: begin
                if (!stat.out_busy) begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FREE: begin
                if (!stat.out_busy) begin
                    cmd.finish_free = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_BUMP_A: begin
                cmd.bump_top = 1'b1;
                state_next   = ST_BUMP_B;
            end
            ST_BUMP_B: begin
                cmd.bump_align = 1'b1;
                state_next     = ST_BUMP_C;
            end
            ST_BUMP_C: begin
                cmd.bump_offset = 1'b1;
                state_next      = ST_BUMP_D;
            end
            ST_BUMP_D: begin
                cmd.bump_size = 1'b1;
                state_next    = ST_BUMP_E;
            end
            ST_BUMP_E: begin
                cmd.bump_compare = 1'b1;
                state_next       = ST_BUMP_F;
            end
            ST_BUMP_F: begin
                cmd.bump_page = 1'b1;
                state_next    = ST_BUMP_END;
            end
            ST_BUMP_END: begin
                if (!stat.out_busy) begin
                    cmd.finish_bump = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- hdl/asbfa_datapath.sv -----
// ----------------------------------------------------------------------------
// Arena stack allocator datapath
// Holds the configuration, the offsets, the free-slot memories, the scan
// pipeline, the bump arithmetic and the result register.
// ----------------------------------------------------------------------------
module asbfa_datapath #(
    parameter int FREE_SLOTS = asbfa_pkg::FREE_SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  asbfa_pkg::cmd_t                   cmd,
    output asbfa_pkg::stat_t                  stat,
    input  logic                              cfg_we,
    input  logic [asbfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asbfa_pkg::ADDR_W-1:0]      cfg_wdata,
    input  logic [asbfa_pkg::OP_W-1:0]        s_opcode,
    input  logic [asbfa_pkg::ALIGN_W-1:0]     s_align_bytes,
    input  logic [asbfa_pkg::SIZE_W-1:0]      s_request_bytes,
    input  logic [asbfa_pkg::ADDR_W-1:0]      s_block_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [asbfa_pkg::ADDR_W-1:0]      m_grant_address,
    output logic [asbfa_pkg::STATUS_W-1:0]    m_status,
    output logic                              m_reused,
    output logic [asbfa_pkg::SIZE_W-1:0]      m_commit_grow_bytes
);

    localparam int ADDR_W   = asbfa_pkg::ADDR_W;
    localparam int SIZE_W   = asbfa_pkg::SIZE_W;
    localparam int ALIGN_W  = asbfa_pkg::ALIGN_W;
    localparam int SUM_W    = asbfa_pkg::SUM_W;
    localparam int STATUS_W = asbfa_pkg::STATUS_W;
    localparam int CNT_W    = $clog2(FREE_SLOTS + 1);
    localparam int IDX_W    = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;

    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(FREE_SLOTS);
    localparam logic [SUM_W-1:0] PAGE_MASK = SUM_W'(asbfa_pkg::PAGE_BYTES - 1);

    // Alignment mask: smallest power of two not below the request, minus one.
    function automatic logic [ALIGN_W-1:0] align_mask(input logic [ALIGN_W-1:0] req);
        logic [ALIGN_W-1:0] m;
        m = (req > ALIGN_W'(1)) ? (req - ALIGN_W'(1)) : '0;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

    // Free-slot storage
    logic                  valid_mem [FREE_SLOTS];
    logic [ADDR_W-1:0]     addr_mem  [FREE_SLOTS];
    logic [SIZE_W-1:0]     size_mem  [FREE_SLOTS];

    // Configuration and allocator state
    logic [ADDR_W-1:0]     base_reg;
    logic [SIZE_W-1:0]     region_reg;
    logic [SIZE_W-1:0]     top_reg;
    logic [SIZE_W-1:0]     saved_reg;
    logic [SIZE_W-1:0]     committed_reg;

    // Latched transaction
    logic [asbfa_pkg::OP_W-1:0] op_reg;
    logic [ALIGN_W-1:0]    mask_reg;
    logic [SIZE_W-1:0]     req_reg;
    logic [ADDR_W-1:0]     blk_reg;

    // Scan pipeline
    logic [CNT_W-1:0]      cnt_reg;
    logic                  data_ok_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [SIZE_W-1:0]     rd_size_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [ADDR_W-1:0]     best_addr_reg;
    logic [SIZE_W-1:0]     best_size_reg;

    // Bump arithmetic
    logic [SUM_W-1:0]      top_addr_reg;
    logic [SUM_W-1:0]      aligned_reg;
    logic [SUM_W-1:0]      off_reg;
    logic [SUM_W-1:0]      end_off_reg;
    logic                  over_reg;
    logic                  grow_reg;
    logic [SUM_W-1:0]      short_reg;
    logic [SUM_W-1:0]      delta_reg;

    // Result register
    logic                  m_valid_reg;
    logic [ADDR_W-1:0]     grant_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  reused_reg;
    logic [SIZE_W-1:0]     grow_out_reg;

    logic                  op_free;
    logic                  cnt_live;
    logic [IDX_W-1:0]      cnt_idx;
    logic                  elig_alloc;
    logic                  elig_free;
    logic                  take;
    logic                  finish_any;
    logic                  vwe;
    logic [IDX_W-1:0]      vwa;
    logic                  vwd;
    logic [SUM_W-1:0]      mask_wide;

    assign op_free   = (op_reg == asbfa_pkg::OP_FREE);
    assign cnt_live  = (cnt_reg < CNT_END);
    assign cnt_idx   = cnt_reg[IDX_W-1:0];
    assign mask_wide = SUM_W'(mask_reg);

    assign elig_alloc = rd_valid_reg
                     && ((rd_addr_reg[ALIGN_W-1:0] & mask_reg) == '0)
                     && (rd_size_reg >= req_reg)
                     && (!found_reg || (rd_size_reg < best_size_reg));
    assign elig_free  = !rd_valid_reg && !found_reg;
    assign take       = data_ok_reg && (op_free ? elig_free : elig_alloc);

    assign finish_any = cmd.finish_simple | cmd.finish_hit | cmd.finish_free
                      | cmd.finish_bump;

    assign stat.clear_done = (cnt_reg == CNT_END);
    assign stat.scan_done  = (cnt_reg == CNT_END) && !data_ok_reg;
    assign stat.found      = found_reg;
    assign stat.op_alloc   = (op_reg == asbfa_pkg::OP_ALLOC);
    assign stat.op_free    = op_free;
    assign stat.out_busy   = m_valid_reg && !m_ready;

    // One write port on the valid store: clearing, hit and free never overlap.
    always_comb begin
        vwe = 1'b0;
        vwa = best_idx_reg;
        vwd = 1'b0;
        priority if (cmd.clear_step) begin
            vwe = cnt_live;
            vwa = cnt_idx;
        end else if (cmd.finish_hit) begin
            vwe = 1'b1;
        end else if (cmd.finish_free) begin
            vwe = found_reg;
            vwd = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (vwe) begin
            valid_mem[vwa] <= vwd;
        end
        if (cmd.finish_free && found_reg) begin
            addr_mem[best_idx_reg] <= blk_reg;
            size_mem[best_idx_reg] <= req_reg;
        end
        if (cmd.scan_step && cnt_live) begin
            rd_valid_reg <= valid_mem[cnt_idx];
            rd_addr_reg  <= addr_mem[cnt_idx];
            rd_size_reg  <= size_mem[cnt_idx];
            rd_idx_reg   <= cnt_idx;
        end
    end

    // Control: slot counter, scan progress and result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            data_ok_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                cnt_reg     <= '0;
                data_ok_reg <= 1'b0;
                found_reg   <= 1'b0;
            end else if (cmd.clear_step || cmd.scan_step) begin
                if (cnt_live) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                data_ok_reg <= cmd.scan_step && cnt_live;
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
            m_valid_reg <= finish_any || (m_valid_reg && !m_ready);
        end
    end

    // Best candidate so far; only its slot index, address and size matter.
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && take) begin
            best_idx_reg  <= rd_idx_reg;
            best_addr_reg <= rd_addr_reg;
            best_size_reg <= rd_size_reg;
        end
        if (cmd.accept) begin
            op_reg   <= s_opcode;
            mask_reg <= align_mask(s_align_bytes);
            req_reg  <= s_request_bytes;
            blk_reg  <= s_block_address;
        end
        if (cmd.bump_top) begin
            top_addr_reg <= SUM_W'(base_reg) + SUM_W'(top_reg);
        end
        if (cmd.bump_align) begin
            aligned_reg <= (top_addr_reg + mask_wide) & ~mask_wide;
        end
        if (cmd.bump_offset) begin
            off_reg <= aligned_reg - SUM_W'(base_reg);
        end
        if (cmd.bump_size) begin
            end_off_reg <= off_reg + SUM_W'(req_reg);
        end
        if (cmd.bump_compare) begin
            over_reg  <= (end_off_reg > SUM_W'(region_reg));
            grow_reg  <= (end_off_reg > SUM_W'(committed_reg));
            short_reg <= end_off_reg - SUM_W'(committed_reg);
        end
        if (cmd.bump_page) begin
            delta_reg <= (short_reg + PAGE_MASK) & ~PAGE_MASK;
        end
    end

    // Architectural state, configuration and result fields.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            region_reg    <= asbfa_pkg::REGION_RESET;
            top_reg       <= '0;
            saved_reg     <= '0;
            committed_reg <= SIZE_W'(asbfa_pkg::PAGE_BYTES);
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    asbfa_pkg::CFG_BASE:   base_reg   <= cfg_wdata;
                    asbfa_pkg::CFG_REGION: region_reg <= cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish_simple) begin
                unique case (op_reg)
                    asbfa_pkg::OP_POP: begin
                        if (top_reg >= req_reg) begin
                            top_reg <= top_reg - req_reg;
                        end
                    end
                    asbfa_pkg::OP_SAVE:    saved_reg <= top_reg;
                    asbfa_pkg::OP_RESTORE: top_reg   <= saved_reg;
                    asbfa_pkg::OP_RESET:   top_reg   <= '0;
                    default: ;
                endcase
            end
            if (cmd.finish_bump && !over_reg) begin
                top_reg <= end_off_reg[SIZE_W-1:0];
                if (grow_reg) begin
                    committed_reg <= committed_reg + delta_reg[SIZE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_any) begin
            grant_reg    <= '0;
            status_reg   <= asbfa_pkg::STATUS_OK;
            reused_reg   <= 1'b0;
            grow_out_reg <= '0;
            if (cmd.finish_simple && op_reg == asbfa_pkg::OP_POP && top_reg < req_reg) begin
                status_reg <= asbfa_pkg::STATUS_UNDERFLOW;
            end
            if (cmd.finish_hit) begin
                grant_reg  <= best_addr_reg;
                reused_reg <= 1'b1;
            end
            if (cmd.finish_free && !found_reg) begin
                status_reg <= asbfa_pkg::STATUS_FULL;
            end
            if (cmd.finish_bump) begin
                if (over_reg) begin
                    status_reg <= asbfa_pkg::STATUS_REGION;
                end else begin
                    grant_reg <= aligned_reg[ADDR_W-1:0];
                    if (grow_reg) begin
                        grow_out_reg <= delta_reg[SIZE_W-1:0];
                    end
                end
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_grant_address     = grant_reg;
    assign m_status            = status_reg;
    assign m_reused            = reused_reg;
    assign m_commit_grow_bytes = grow_out_reg;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        finish_any |-> !(m_valid_reg && !m_ready))
        else $error("result loaded while output register still held");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        finish_any |=> m_valid_reg)
        else $error("finished transaction did not raise the output valid");

    a_reuse_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && reused_reg) |-> (status_reg == asbfa_pkg::STATUS_OK))
        else $error("free-list hit reported with an error status");

    a_commit_paged: assert property (@(posedge aclk) disable iff (!aresetn)
        committed_reg[asbfa_pkg::PAGE_SHIFT-1:0] == '0)
        else $error("committed size is not a whole number of pages");

    a_accept_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (!data_ok_reg && (cnt_reg == CNT_END)))
        else $error("transaction accepted while the slot counter was busy");

endmodule

// ----- hdl/arena_stack_best_fit_allocator_unit.sv -----
// Flow: allocate and free scan the free list first; an allocate that misses runs the
// bump steps, and all other opcodes go to the result register once it is free.
// Throughput: one transaction at a time; each allocate or free scans the slot
// memories in full, one slot per cycle.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the slot valid
// store before the first transaction is accepted.
// ----------------------------------------------------------------------------
// Arena stack allocator with best-fit free list
// Bump allocator over a configured region with a table of freed blocks that
// allocations search first for the smallest aligned block that fits.
// ----------------------------------------------------------------------------
module arena_stack_best_fit_allocator_unit #(
    parameter int FREE_SLOTS = asbfa_pkg::FREE_SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [asbfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asbfa_pkg::ADDR_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [asbfa_pkg::OP_W-1:0]        s_opcode,
    input  logic [asbfa_pkg::ALIGN_W-1:0]     s_align_bytes,
    input  logic [asbfa_pkg::SIZE_W-1:0]      s_request_bytes,
    input  logic [asbfa_pkg::ADDR_W-1:0]      s_block_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [asbfa_pkg::ADDR_W-1:0]      m_grant_address,
    output logic [asbfa_pkg::STATUS_W-1:0]    m_status,
    output logic                              m_reused,
    output logic [asbfa_pkg::SIZE_W-1:0]      m_commit_grow_bytes
);

    asbfa_pkg::cmd_t  cmd;
    asbfa_pkg::stat_t stat;

    asbfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    asbfa_datapath #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_opcode            (s_opcode),
        .s_align_bytes       (s_align_bytes),
        .s_request_bytes     (s_request_bytes),
        .s_block_address     (s_block_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_grant_address     (m_grant_address),
        .m_status            (m_status),
        .m_reused            (m_reused),
        .m_commit_grow_bytes (m_commit_grow_bytes)
    );

endmodule
